// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL files of the scalar Kalman filter.
// No dependencies; included by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked property, switched off while reset is applied.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that also holds during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- design/skf_pkg.sv -----
// Shared types and constants of the scalar Kalman filter.
// No dependencies; used by skf_ctrl, skf_dp and scalar_kalman_filter.
package skf_pkg;

    // Fixed-point widths of the item fields and the state.
    localparam int DataW  = 32;
    localparam int GainW  = 16;
    localparam int FracW  = 16;

    // The gain quotient carries one bit above the Q0.16 range.
    localparam int DivSteps = GainW + 1;
    localparam int CntW     = $clog2(DivSteps);

    // Configuration port.
    localparam int CfgIdxW = 4;
    localparam logic [CfgIdxW-1:0] CFG_MEAS_NOISE = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] CFG_PROC_NOISE = CfgIdxW'(1);

    // Register reset values.
    localparam logic [DataW-1:0] MEAS_NOISE_RST = 32'd65536;
    localparam logic [DataW-1:0] PROC_NOISE_RST = 32'd655;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic pred;
        logic div_step;
        logic mul_err;
        logic upd_est;
        logic mul_cov;
        logic upd_cov;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

// ----- design/scalar_kalman_filter.sv -----
// Scalar Kalman filter top level: one item at a time; the input opens again only
// once the result has gone into the output register. Each item passes prediction,
// the 17-step restoring gain divider and four more steps with the shared multiplier.
// Synchronous active-low reset gives estimate 0, covariance 0, R = 1.0, Q = 655.
// Contains skf_ctrl and skf_dp; uses skf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scalar_kalman_filter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [skf_pkg::DataW-1:0]  i_measurement,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [skf_pkg::DataW-1:0]  o_estimate,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [skf_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [skf_pkg::DataW-1:0]         i_cfg_data
);

    skf_pkg::t_dp_cmd     w_cmd;
    skf_pkg::t_dp_status  w_status;

    // Sequencer.
    skf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and storage.
    skf_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_measurement (i_measurement),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_estimate    (o_estimate)
    );

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    // An accepted item keeps the input closed while it is worked on.
    `ASSERT_RST(a_busy_after_accept, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "input still ready after an item was accepted")
    // The controller only fills the output register when it has room.
    `ASSERT_RST(a_load_needs_room, i_clk, i_rst_n, w_cmd.load_out |-> w_status.out_free, "output register overwritten")
    // Reset empties the output register.
    `ASSERT_ALWAYS(a_reset_clears_out, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

// ----- design/skf_ctrl.sv -----
// Sequencer of the scalar Kalman filter: steps one item through prediction,
// gain division, both corrections and hand-off. Depends on skf_pkg.
module skf_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  skf_pkg::t_dp_status  i_status,
    output skf_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRED,
        S_DIV,
        S_MULX,
        S_UPDX,
        S_MULP,
        S_UPDP,
        S_FIN
    } t_state;

    t_state                      r_state;
    logic [skf_pkg::CntW-1:0]    r_cnt;

    // State and division step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_PRED;
                    end
                end
                S_PRED: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == skf_pkg::CntW'(skf_pkg::DivSteps - 1)) begin
                        r_state <= S_MULX;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_MULX: r_state <= S_UPDX;
                S_UPDX: r_state <= S_MULP;
                S_MULP: r_state <= S_UPDP;
                S_UPDP: r_state <= S_FIN;
                S_FIN: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Commands decoded from the state.
    always_comb begin
        o_cmd          = '0;
        o_cmd.load_in  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.pred     = (r_state == S_PRED);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.mul_err  = (r_state == S_MULX);
        o_cmd.upd_est  = (r_state == S_UPDX);
        o_cmd.mul_cov  = (r_state == S_MULP);
        o_cmd.upd_cov  = (r_state == S_UPDP);
        o_cmd.load_out = (r_state == S_FIN) && i_status.out_free;
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ----- design/skf_dp.sv -----
// Datapath of the scalar Kalman filter: configuration registers, filter state,
// restoring gain divider, shared multiplier and output register. Uses skf_pkg.
module skf_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  skf_pkg::t_dp_cmd                  i_cmd,
    output skf_pkg::t_dp_status               o_status,
    input  logic signed [skf_pkg::DataW-1:0]  i_measurement,
    input  logic                              i_cfg_valid,
    input  logic [skf_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [skf_pkg::DataW-1:0]         i_cfg_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [skf_pkg::DataW-1:0]  o_estimate
);

    localparam int W  = skf_pkg::DataW;
    localparam int GW = skf_pkg::GainW;
    localparam int FW = skf_pkg::FracW;
    localparam int MulAW = GW + 2;
    localparam int MulBW = W + 2;
    localparam int ProdW = MulAW + MulBW;
    localparam int SumW  = W + 4;

    // Configuration and filter state.
    logic [W-1:0]           r_meas_noise;
    logic [W-1:0]           r_proc_noise;
    logic signed [W-1:0]    r_est;
    logic [W-1:0]           r_cov;

    // Working registers of one item.
    logic signed [W-1:0]    r_meas;
    logic [W-1:0]           r_p1;
    logic [W:0]             r_den;
    logic                   r_den_zero;
    logic [W+1:0]           r_rem;
    logic [GW:0]            r_quo;
    logic signed [W:0]      r_err;
    logic signed [ProdW-1:0] r_prod;

    // Output register.
    logic                   r_out_valid;
    logic signed [W-1:0]    r_out_est;

    logic [W:0]             w_p_sum;
    logic [W-1:0]           w_p1;
    logic [W:0]             w_den;
    logic                   w_ge;
    logic [W+1:0]           w_rem_sub;
    logic [GW-1:0]          w_gain;
    logic [GW:0]            w_one_minus;
    logic signed [MulAW-1:0] w_mul_a;
    logic signed [MulBW-1:0] w_mul_b;
    logic signed [ProdW-1:0] w_mul_p;
    logic signed [ProdW-1:0] w_round;
    logic signed [SumW-1:0]  w_delta;
    logic signed [SumW-1:0]  w_xsum;
    logic signed [W-1:0]     w_xnew;
    logic [W:0]              w_pnew;

    // Prediction: saturating covariance growth and the gain denominator.
    assign w_p_sum = {1'b0, r_cov} + {1'b0, r_proc_noise};
    assign w_p1    = w_p_sum[W] ? {W{1'b1}} : w_p_sum[W-1:0];
    assign w_den   = {1'b0, w_p1} + {1'b0, r_meas_noise};

    // One restoring division step: compare, subtract, record a quotient bit.
    assign w_ge      = (r_rem >= {1'b0, r_den});
    assign w_rem_sub = r_rem - {1'b0, r_den};

    // Gain in Q0.16; a quotient of exactly one saturates, a zero divisor gives 0.
    assign w_gain = r_den_zero ? '0 :
                    r_quo[GW] ? {GW{1'b1}} : r_quo[GW-1:0];
    assign w_one_minus = {1'b1, {GW{1'b0}}} - {1'b0, w_gain};

    // Shared multiplier: gain times error, then (1 - gain) times covariance.
    always_comb begin
        if (i_cmd.mul_cov) begin
            w_mul_a = $signed({1'b0, w_one_minus});
            w_mul_b = $signed({2'b00, r_p1});
        end else begin
            w_mul_a = $signed({2'b00, w_gain});
            w_mul_b = $signed({r_err[W], r_err});
        end
    end
    assign w_mul_p = w_mul_a * w_mul_b;

    // Rounding half up, then the estimate update with a clamp.
    assign w_round = r_prod + ProdW'(32768);
    assign w_delta = SumW'(w_round >>> FW);
    assign w_xsum  = SumW'(r_est) + w_delta;
    always_comb begin
        if (w_xsum > SumW'(32'sh7FFF_FFFF)) begin
            w_xnew = {1'b0, {(W-1){1'b1}}};
        end else if (w_xsum < -(SumW'(33'sh0_8000_0000))) begin
            w_xnew = {1'b1, {(W-1){1'b0}}};
        end else begin
            w_xnew = w_xsum[W-1:0];
        end
    end
    assign w_pnew = w_round[FW+W:FW];

    // Configuration registers, taken from the write port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meas_noise <= skf_pkg::MEAS_NOISE_RST;
            r_proc_noise <= skf_pkg::PROC_NOISE_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == skf_pkg::CFG_MEAS_NOISE) begin
                r_meas_noise <= i_cfg_data;
            end else if (i_cfg_index == skf_pkg::CFG_PROC_NOISE) begin
                r_proc_noise <= i_cfg_data;
            end
        end
    end

    // Filter state, updated once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_est <= '0;
            r_cov <= '0;
        end else begin
            if (i_cmd.upd_est) begin
                r_est <= w_xnew;
            end
            if (i_cmd.upd_cov) begin
                r_cov <= w_pnew[W] ? {W{1'b1}} : w_pnew[W-1:0];
            end
        end
    end

    // Working registers of the item in flight.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_meas <= i_measurement;
        end
        if (i_cmd.pred) begin
            r_p1       <= w_p1;
            r_den      <= w_den;
            r_den_zero <= (w_den == '0);
            r_rem      <= {2'b00, w_p1};
            r_quo      <= '0;
            r_err      <= $signed({r_meas[W-1], r_meas}) - $signed({r_est[W-1], r_est});
        end
        if (i_cmd.div_step) begin
            if (w_ge) begin
                r_rem <= {w_rem_sub[W:0], 1'b0};
                r_quo <= {r_quo[GW-1:0], 1'b1};
            end else begin
                r_rem <= {r_rem[W:0], 1'b0};
                r_quo <= {r_quo[GW-1:0], 1'b0};
            end
        end
        if (i_cmd.mul_err || i_cmd.mul_cov) begin
            r_prod <= w_mul_p;
        end
    end

    // Output register: holds a finished item until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_est <= r_est;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_estimate        = r_out_est;

endmodule
